// ===== rtl/heightmap_terrain_engine_assert.svh =====
// Assertion macros used by the checker file of the height map engine.
`ifndef HEIGHTMAP_TERRAIN_ENGINE_ASSERT_SVH
`define HEIGHTMAP_TERRAIN_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HTE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("height map engine assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("height map engine assertion failed");

// Next-cycle implication that also holds across reset.
`define HTE_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("height map engine reset assertion failed");

`endif

// ===== rtl/hte_pkg.sv =====
// -----------------------------------------------------------------------------
// Height map engine package
// Field widths, stream packing offsets and command codes.
// -----------------------------------------------------------------------------
`default_nettype none

package hte_pkg;

    localparam int KIND_W      = 2;
    localparam int METHOD_W    = 2;
    localparam int CELL_W      = 14;
    localparam int RADIUS_W    = 6;
    localparam int DIR_W       = 5;
    localparam int HEIGHT_W    = 24;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Input tdata offsets, lowest field first.
    localparam int OFS_FIRST   = 0;
    localparam int OFS_SECOND  = OFS_FIRST + CELL_W;
    localparam int OFS_RADIUS  = OFS_SECOND + CELL_W;
    localparam int OFS_DIR     = OFS_RADIUS + RADIUS_W;
    localparam int IN_USED_W   = OFS_DIR + DIR_W;
    localparam int OUT_USED_W  = HEIGHT_W + CELL_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_GEN    = 2'd0,
        KIND_SMOOTH = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [METHOD_W-1:0] {
        METHOD_FAULT    = 2'd0,
        METHOD_CIRCLE   = 2'd1,
        METHOD_PARTICLE = 2'd2,
        METHOD_NONE     = 2'd3
    } t_method;

    // Walker direction code limits.
    localparam logic [DIR_W-1:0] DIR_RIGHT_MAX = 5'd5;
    localparam logic [DIR_W-1:0] DIR_LEFT_MAX  = 5'd11;
    localparam logic [DIR_W-1:0] DIR_DOWN_MAX  = 5'd17;
    localparam logic [DIR_W-1:0] DIR_UP_MAX    = 5'd23;
    localparam logic [DIR_W-1:0] DIR_JUMP      = 5'd24;

    // One unit of height in Q15.8 and the saturation limits.
    localparam logic signed [HEIGHT_W:0] H_ONE = 25'sd256;
    localparam logic signed [HEIGHT_W:0] H_MAX = 25'sd8388607;
    localparam logic signed [HEIGHT_W:0] H_MIN = -25'sd8388608;

    // Divide by three: x / 3 == (x * RECIP3) >> RECIP3_SH for x below 2**27.
    localparam int RECIP3_W  = 26;
    localparam int RECIP3_SH = 27;
    localparam logic [RECIP3_W-1:0] RECIP3 = 26'h2AAAAAB;

endpackage

`default_nettype wire

// ===== rtl/hte_ram.sv =====
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// -----------------------------------------------------------------------------
`default_nettype none

module hte_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/heightmap_terrain_engine.sv =====
// -----------------------------------------------------------------------------
// Height map terrain engine
// Keeps a COLS x ROWS grid of Q15.8 heights in one RAM and runs fault line,
// circle, particle, smoothing, read and clear commands over it.
// -----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the slave stream, one transaction per command, with the
//   command kind in tuser. Only a read command produces a transaction on the
//   master stream. The method register is written through i_cfg_we; the user
//   writes it only while the engine is idle, which the block does not enforce.
// Command flow (N = COLS*ROWS):
//   Every command but smoothing first reduces its cell indexes modulo N by
//   repeated subtraction. Fault and circle steps then split the cells into
//   row and column the same way, pass setup states A to C and sweep the grid
//   at one cell a cycle, then drain. A clear zeroes the grid, a particle step
//   reads its cell and writes it back raised, and a read may wait for the output.
//   Smoothing reads, sums, scales by one third and writes each cell in turn,
//   over two passes of (COLS-1)*(ROWS-1) cells each.
// Reset: a clearing pass zeroes the grid; tready stays low during it. The
//   walker goes to cell 0 and the method to none.
// Stalls: a read result waits in the output register; a later read command
//   holds until the result has been taken.
// -----------------------------------------------------------------------------
`default_nettype none

module heightmap_terrain_engine
    import hte_pkg::*;
#(
    parameter int COLS = 128,
    parameter int ROWS = 128
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [METHOD_W-1:0]    i_cfg_wdata,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // first_cell[13:0], second_cell[27:14], radius[33:28], direction[38:34]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // kind[1:0]
    input  wire logic [KIND_W-1:0]      i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // cell_height[23:0], cell_index[37:24]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int NCELLS = COLS * ROWS;
    localparam int IW     = $clog2(NCELLS);
    localparam int CCW    = $clog2(COLS);
    localparam int RCW    = $clog2(ROWS);
    localparam int MW     = (CCW > RCW) ? CCW : RCW;
    localparam int SQW    = 2 * MW + 2;
    localparam int CMPW   = (SQW > 2 * RADIUS_W) ? SQW : 2 * RADIUS_W;
    localparam int FW     = RCW + CCW + 4;
    localparam int PRDW   = HEIGHT_W + 1 + RECIP3_W;
    localparam logic [CELL_W:0]   NC_LIM   = (NCELLS > 16383) ? 15'd16384 : 15'(NCELLS);
    localparam logic [CELL_W-1:0] COLS_C   = CELL_W'(COLS);
    localparam logic [IW-1:0]     LAST_IDX = IW'(NCELLS - 1);
    localparam logic [IW-1:0]     DOWN_LIM = IW'(COLS * (ROWS - 1));
    localparam logic [IW-1:0]     COLS_I   = IW'(COLS);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_MOD, ST_SPLIT, ST_SETUP_A, ST_SETUP_B, ST_SETUP_C,
        ST_SWEEP, ST_DRAIN, ST_PART_RD, ST_PART_WR, ST_READ, ST_READ_OUT,
        ST_SM_RD1, ST_SM_RD2, ST_SM_SUM, ST_SM_MUL, ST_SM_WR
    } t_state;

    typedef enum logic [1:0] {D_NONE, D_UP, D_DOWN} t_delta;

    t_state                     r_state;
    t_method                    r_method;
    t_kind                      r_kind;
    logic [CELL_W-1:0]          r_c1, r_c2, r_rem1, r_rem2;
    logic [RCW-1:0]             r_row1, r_row2;
    logic [RADIUS_W-1:0]        r_radius;
    logic [DIR_W-1:0]           r_dir;
    logic [IW-1:0]              r_walk, r_addr, r_p_addr;
    logic [CCW-1:0]             r_col;
    logic [RCW-1:0]             r_row;
    logic                       r_bwd, r_p_valid, r_fault;
    t_delta                     r_p_delta;
    logic signed [RCW:0]        r_a;
    logic signed [CCW:0]        r_b;
    logic signed [FW-1:0]       r_prod, r_acc, r_rowacc;
    logic [SQW-1:0]             r_dzsq;
    logic signed [HEIGHT_W:0]   r_s;
    logic                       r_neg;
    logic [HEIGHT_W:0]          r_mag;
    logic [PRDW-1:0]            r_prd;
    logic                       r_ovalid;
    logic [HEIGHT_W-1:0]        r_oheight;
    logic [CELL_W-1:0]          r_oindex;

    logic [HEIGHT_W-1:0]        w_rdata_a, w_rdata_b, w_wdata;
    logic [IW-1:0]              w_raddr_a, w_raddr_b, w_waddr;
    logic                       w_we;
    logic [CCW-1:0]             w_col1;
    logic signed [CCW:0]        w_dx;
    logic signed [2*CCW+1:0]    w_dx2;
    logic signed [RCW:0]        w_dzn;
    logic signed [2*RCW+1:0]    w_dzn2;
    logic [CMPW-1:0]            w_sq, w_r2;
    t_delta                     w_delta;
    logic                       w_col_wrap, w_last;
    logic signed [FW-1:0]       w_acc0;
    logic signed [HEIGHT_W+1:0] w_s3;
    logic [HEIGHT_W-1:0]        w_q;
    logic [IW-1:0]              n_addr;
    logic [CCW-1:0]             n_col;
    logic [RCW-1:0]             n_row;
    logic                       n_bwd, w_sm_done;
    logic                       w_accept;

    function automatic logic [HEIGHT_W-1:0] f_bump(input logic [HEIGHT_W-1:0] h,
                                                   input logic up);
        logic signed [HEIGHT_W:0] v;
        v = $signed({h[HEIGHT_W-1], h}) + (up ? H_ONE : -H_ONE);
        if (v > H_MAX) begin
            v = H_MAX;
        end else if (v < H_MIN) begin
            v = H_MIN;
        end
        return v[HEIGHT_W-1:0];
    endfunction

    hte_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (NCELLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), r_oindex, r_oheight};

    // Circle and fault geometry. The fault value a*x + b*z - c is carried
    // incrementally: +a per column, +b per row.
    assign w_col1 = r_rem1[CCW-1:0];
    assign w_dx   = $signed({1'b0, r_col}) - $signed({1'b0, w_col1});
    assign w_dx2  = w_dx * w_dx;
    assign w_dzn  = $signed({1'b0, RCW'(r_row + 1'b1)}) - $signed({1'b0, r_row1});
    assign w_dzn2 = w_dzn * w_dzn;
    assign w_sq   = CMPW'($unsigned(w_dx2)) + CMPW'(r_dzsq);
    assign w_r2   = CMPW'(r_radius * r_radius);
    assign w_acc0 = -(r_prod + FW'(r_b * $signed({1'b0, r_row1})));

    always_comb begin
        if (r_fault) begin
            w_delta = (!r_acc[FW-1] && (r_acc != '0)) ? D_UP : D_DOWN;
        end else begin
            w_delta = (w_sq < w_r2) ? D_UP : D_NONE;
        end
    end

    assign w_col_wrap = (r_col == CCW'(COLS - 1));
    assign w_last     = (r_addr == LAST_IDX);

    // Smoothing: sum of three, then magnitude times the reciprocal of three.
    assign w_s3 = {r_s[HEIGHT_W], r_s} + {{2{w_rdata_a[HEIGHT_W-1]}}, w_rdata_a};
    assign w_q  = r_prd[RECIP3_SH +: HEIGHT_W];

    // Next cell of the forward and backward smoothing passes.
    always_comb begin
        n_addr    = r_addr;
        n_col     = r_col;
        n_row     = r_row;
        n_bwd     = r_bwd;
        w_sm_done = 1'b0;
        if (!r_bwd) begin
            if (r_col != CCW'(COLS - 2)) begin
                n_addr = r_addr + 1'b1;
                n_col  = r_col + 1'b1;
            end else if (r_row != RCW'(ROWS - 2)) begin
                n_addr = r_addr + IW'(2);
                n_col  = '0;
                n_row  = r_row + 1'b1;
            end else begin
                n_bwd  = 1'b1;
                n_addr = LAST_IDX;
                n_col  = CCW'(COLS - 1);
                n_row  = RCW'(ROWS - 1);
            end
        end else begin
            if (r_col != CCW'(1)) begin
                n_addr = r_addr - 1'b1;
                n_col  = r_col - 1'b1;
            end else if (r_row != RCW'(1)) begin
                n_addr = r_addr - IW'(2);
                n_col  = CCW'(COLS - 1);
                n_row  = r_row - 1'b1;
            end else begin
                w_sm_done = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (r_state)
            ST_PART_RD:            w_raddr_a = r_walk;
            ST_READ, ST_READ_OUT:  w_raddr_a = IW'(r_c1);
            ST_SM_RD2:             w_raddr_a = r_bwd ? (r_addr - COLS_I) : (r_addr + COLS_I);
            default:               w_raddr_a = r_addr;
        endcase
        w_raddr_b = r_bwd ? (r_addr - 1'b1) : (r_addr + 1'b1);
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        priority if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (r_p_valid) begin
            w_we    = (r_p_delta != D_NONE);
            w_waddr = r_p_addr;
            w_wdata = f_bump(w_rdata_a, r_p_delta == D_UP);
        end else if (r_state == ST_PART_WR) begin
            w_we    = 1'b1;
            w_waddr = r_walk;
            w_wdata = f_bump(w_rdata_a, 1'b1);
        end else if (r_state == ST_SM_WR) begin
            w_we    = 1'b1;
            w_wdata = r_neg ? (HEIGHT_W'(0) - w_q) : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_method  <= METHOD_NONE;
            r_addr    <= '0;
            r_walk    <= '0;
            r_ovalid  <= 1'b0;
            r_p_valid <= 1'b0;
            r_bwd     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_method <= t_method'(i_cfg_wdata);
            end
            if (r_state == ST_READ_OUT && (!r_ovalid || i_m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_p_valid <= (r_state == ST_SWEEP);
            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (w_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_kind   <= t_kind'(i_s_axis_tuser);
                        r_c1     <= i_s_axis_tdata[OFS_FIRST +: CELL_W];
                        r_c2     <= i_s_axis_tdata[OFS_SECOND +: CELL_W];
                        r_radius <= i_s_axis_tdata[OFS_RADIUS +: RADIUS_W];
                        r_dir    <= i_s_axis_tdata[OFS_DIR +: DIR_W];
                        r_addr   <= '0;
                        r_col    <= '0;
                        r_row    <= '0;
                        r_bwd    <= 1'b0;
                        r_state  <= (t_kind'(i_s_axis_tuser) == KIND_SMOOTH) ?
                                    ST_SM_RD1 : ST_MOD;
                    end
                end
                ST_MOD: begin
                    if ({1'b0, r_c1} >= NC_LIM || {1'b0, r_c2} >= NC_LIM) begin
                        if ({1'b0, r_c1} >= NC_LIM) begin
                            r_c1 <= r_c1 - NC_LIM[CELL_W-1:0];
                        end
                        if ({1'b0, r_c2} >= NC_LIM) begin
                            r_c2 <= r_c2 - NC_LIM[CELL_W-1:0];
                        end
                    end else begin
                        r_rem1 <= r_c1;
                        r_rem2 <= r_c2;
                        r_row1 <= '0;
                        r_row2 <= '0;
                        r_fault <= (r_method == METHOD_FAULT);
                        unique case (r_kind)
                            KIND_CLEAR: begin
                                r_walk  <= IW'(r_c1);
                                r_state <= ST_CLEAR;
                            end
                            KIND_READ:   r_state <= ST_READ;
                            KIND_SMOOTH: r_state <= ST_IDLE;
                            KIND_GEN: begin
                                unique case (r_method)
                                    METHOD_FAULT, METHOD_CIRCLE: r_state <= ST_SPLIT;
                                    METHOD_PARTICLE:             r_state <= ST_PART_RD;
                                    METHOD_NONE:                 r_state <= ST_IDLE;
                                    default:                     r_state <= ST_IDLE;
                                endcase
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SPLIT: begin
                    if (r_rem1 >= COLS_C || r_rem2 >= COLS_C) begin
                        if (r_rem1 >= COLS_C) begin
                            r_rem1 <= r_rem1 - COLS_C;
                            r_row1 <= r_row1 + 1'b1;
                        end
                        if (r_rem2 >= COLS_C) begin
                            r_rem2 <= r_rem2 - COLS_C;
                            r_row2 <= r_row2 + 1'b1;
                        end
                    end else begin
                        r_state <= ST_SETUP_A;
                    end
                end
                ST_SETUP_A: begin
                    r_a     <= $signed({1'b0, r_row2}) - $signed({1'b0, r_row1});
                    r_b     <= $signed({1'b0, w_col1}) - $signed({1'b0, r_rem2[CCW-1:0]});
                    r_dzsq  <= SQW'(r_row1 * r_row1);
                    r_state <= ST_SETUP_B;
                end
                ST_SETUP_B: begin
                    r_prod  <= FW'(r_a * $signed({1'b0, w_col1}));
                    r_state <= ST_SETUP_C;
                end
                ST_SETUP_C: begin
                    r_acc    <= w_acc0;
                    r_rowacc <= w_acc0;
                    r_state  <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    r_p_addr  <= r_addr;
                    r_p_delta <= w_delta;
                    r_addr    <= r_addr + 1'b1;
                    if (w_col_wrap) begin
                        r_col    <= '0;
                        r_row    <= r_row + 1'b1;
                        r_rowacc <= r_rowacc + FW'(r_b);
                        r_acc    <= r_rowacc + FW'(r_b);
                        r_dzsq   <= SQW'($unsigned(w_dzn2));
                    end else begin
                        r_col <= r_col + 1'b1;
                        r_acc <= r_acc + FW'(r_a);
                    end
                    if (w_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN:   r_state <= ST_IDLE;
                ST_PART_RD: r_state <= ST_PART_WR;
                ST_PART_WR: begin
                    if (r_dir <= DIR_RIGHT_MAX) begin
                        if (r_walk < LAST_IDX) begin
                            r_walk <= r_walk + 1'b1;
                        end
                    end else if (r_dir <= DIR_LEFT_MAX) begin
                        if (r_walk != '0) begin
                            r_walk <= r_walk - 1'b1;
                        end
                    end else if (r_dir <= DIR_DOWN_MAX) begin
                        if (r_walk < DOWN_LIM) begin
                            r_walk <= r_walk + COLS_I;
                        end
                    end else if (r_dir <= DIR_UP_MAX) begin
                        if (r_walk >= COLS_I) begin
                            r_walk <= r_walk - COLS_I;
                        end
                    end else if (r_dir == DIR_JUMP) begin
                        r_walk <= IW'(r_c2);
                    end
                    r_state <= ST_IDLE;
                end
                ST_READ: r_state <= ST_READ_OUT;
                ST_READ_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_oheight <= w_rdata_a;
                        r_oindex  <= r_c1;
                        r_state   <= ST_IDLE;
                    end
                end
                ST_SM_RD1: r_state <= ST_SM_RD2;
                ST_SM_RD2: begin
                    r_s     <= $signed({w_rdata_a[HEIGHT_W-1], w_rdata_a})
                             + $signed({w_rdata_b[HEIGHT_W-1], w_rdata_b});
                    r_state <= ST_SM_SUM;
                end
                ST_SM_SUM: begin
                    r_neg   <= w_s3[HEIGHT_W+1];
                    r_mag   <= w_s3[HEIGHT_W+1] ? (HEIGHT_W+1)'(-w_s3)
                                                : (HEIGHT_W+1)'(w_s3);
                    r_state <= ST_SM_MUL;
                end
                ST_SM_MUL: begin
                    r_prd   <= PRDW'(r_mag * RECIP3);
                    r_state <= ST_SM_WR;
                end
                ST_SM_WR: begin
                    r_addr  <= n_addr;
                    r_col   <= n_col;
                    r_row   <= n_row;
                    r_bwd   <= n_bwd;
                    r_state <= w_sm_done ? ST_IDLE : ST_SM_RD1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hte_checker.sv =====
// -----------------------------------------------------------------------------
// Height map engine port checker
// Watches the stream ports of the engine over time.
// -----------------------------------------------------------------------------
`default_nettype none

`include "heightmap_terrain_engine_assert.svh"

module hte_checker
    import hte_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result keeps its valid and its data.
    `HTE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `HTE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata))

    // Commands are worked one at a time: ready drops after each transaction.
    `HTE_ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // Reset starts the clearing pass with no result pending.
    `HTE_ASSERT_ALWAYS_NEXT(a_rst_quiet, i_clk, !i_rst_n, !o_s_axis_tready && !o_m_axis_tvalid)

endmodule

bind heightmap_terrain_engine hte_checker u_hte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
